/* hw/rtl/lcw_pkg.sv */
// ----------------------------------------------------------------------------
// lcw_pkg: shared definitions for the load cell weigher
// Widths, command and register codes, load state codes and the request
// bundle of the serial multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcw_pkg;

    localparam int MAX_POINTS = 8;
    localparam int ADC_BITS   = 24;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int OFF_W  = ADC_BITS + 1;          // tare-relative delta
    localparam int DIF_W  = ADC_BITS + 2;          // difference of two deltas
    localparam int WT_W   = 32;                    // Q24.8 weight
    localparam int WB_W   = WT_W + 1;              // difference of two weights
    localparam int PROD_W = DIF_W + WB_W;          // product magnitude
    localparam int MDC_W  = $clog2(PROD_W + 1);
    localparam int QO_W   = 42;                    // signed quotient, |q| <= 2^40
    localparam int CFG_W  = (ADC_BITS > 31) ? ADC_BITS : 31;
    localparam int IN_DATA_W  = ((ADC_BITS + WT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        CMD_WEIGH = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_TARE      = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_BAND      = 2'd2,
        CFG_NEEDED    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_UNCAL      = 3'd0,
        MODE_IDLE       = 3'd1,
        MODE_NEW        = 3'd2,
        MODE_STABLE     = 3'd3,
        MODE_CHG_STABLE = 3'd4,
        MODE_CHG_UNSTAB = 3'd5,
        MODE_REMOVED    = 3'd6,
        MODE_RSVD       = 3'd7
    } t_mode;

    typedef struct packed {
        logic                    start;
        logic signed [DIF_W-1:0] a;
        logic signed [WB_W-1:0]  b;
        logic signed [DIF_W-1:0] c;
    } t_md_req;

endpackage

`default_nettype wire

/* hw/rtl/lcw_muldiv.sv */
// ----------------------------------------------------------------------------
// lcw_muldiv: serial a*b/c
// Shift-add multiply of the magnitudes, then restoring division one quotient
// bit per cycle; truncates toward zero and caps the magnitude at 2^40.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_muldiv (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  lcw_pkg::t_md_req             i_req,
    output logic                         o_done,
    output logic signed [lcw_pkg::QO_W-1:0] o_quot
);
    import lcw_pkg::*;

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_DONE = 4'b1000
    } t_md_state;

    localparam logic [PROD_W-1:0] Q_CAP = PROD_W'(1) << 40;

    t_md_state          r_state;
    logic               r_neg;
    logic [PROD_W-1:0]  r_mcand;
    logic [DIF_W-1:0]   r_mplier;
    logic [PROD_W-1:0]  r_acc;
    logic [DIF_W-1:0]   r_div;
    logic [DIF_W-1:0]   r_rem;
    logic [MDC_W-1:0]   r_cnt;

    logic [DIF_W:0]     w_rem_sh;
    logic [DIF_W:0]     w_rem_sub;
    logic               w_qbit;
    logic [PROD_W-1:0]  w_qcap;
    logic [QO_W-1:0]    w_qmag;

    assign w_rem_sh  = {r_rem, r_acc[PROD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_div});
    assign w_qcap    = (r_acc > Q_CAP) ? Q_CAP : r_acc;
    assign w_qmag    = w_qcap[QO_W-1:0];
    assign o_quot    = r_neg ? -$signed(w_qmag) : $signed(w_qmag);
    assign o_done    = (r_state == MD_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            unique case (r_state)
                MD_IDLE: if (i_req.start) r_state <= MD_MUL;
                MD_MUL:  if (r_cnt == MDC_W'(DIF_W - 1)) r_state <= MD_DIV;
                MD_DIV:  if (r_cnt == MDC_W'(PROD_W - 1)) r_state <= MD_DONE;
                MD_DONE: r_state <= MD_IDLE;
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MD_IDLE: begin
                r_neg    <= (i_req.a[DIF_W-1] ^ i_req.b[WB_W-1]) ^ i_req.c[DIF_W-1];
                r_mplier <= i_req.a[DIF_W-1] ? DIF_W'(-i_req.a) : DIF_W'(i_req.a);
                r_mcand  <= PROD_W'(i_req.b[WB_W-1] ? WB_W'(-i_req.b) : WB_W'(i_req.b));
                r_div    <= i_req.c[DIF_W-1] ? DIF_W'(-i_req.c) : DIF_W'(i_req.c);
                r_acc    <= '0;
                r_rem    <= '0;
                r_cnt    <= '0;
            end
            MD_MUL: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= (r_cnt == MDC_W'(DIF_W - 1)) ? '0 : r_cnt + 1'b1;
            end
            MD_DIV: begin
                // shift the dividend out at the top, the quotient in at the bottom
                r_rem <= w_qbit ? w_rem_sub[DIF_W-1:0] : w_rem_sh[DIF_W-1:0];
                r_acc <= {r_acc[PROD_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
            end
            MD_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/load_cell_weigher_unit.sv */
// Sequence: weigh walks the segments, runs the serial multiply/divide, classifies
//   and outputs; the multiply/divide is skipped when no division is needed;
//   add and clear use neither step.
// Throughput: one item at a time; s_axis_tready rises with the result valid,
//   later while an earlier result still waits for the sink.
// Reset: synchronous, active low; control, registers and point count cleared.
// ----------------------------------------------------------------------------
// load_cell_weigher_unit: piecewise linear load cell calibration
// Keeps a sorted table of calibration points, converts samples to Q24.8
// grams and tracks load stability.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_weigher_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // adc_sample, known_weight
    input  wire  [lcw_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // command
    input  wire  [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // weight, load_state, points_held, add_rejected
    output logic [lcw_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire                                 i_cfg_we,
    input  wire  [1:0]                          i_cfg_index,
    input  wire  [lcw_pkg::CFG_W-1:0]           i_cfg_data
);
    import lcw_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_INS     = 11'b00000000010,
        S_W0      = 11'b00000000100,
        S_TOP1    = 11'b00000001000,
        S_TOP2    = 11'b00000010000,
        S_SCAN0   = 11'b00000100000,
        S_SCAN    = 11'b00001000000,
        S_MD_GO   = 11'b00010000000,
        S_MD_WAIT = 11'b00100000000,
        S_CLASS   = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } t_state;

    // configuration
    logic signed [ADC_BITS-1:0] r_tare;
    logic [30:0]                r_thr;
    logic [30:0]                r_band;
    logic [7:0]                 r_needed;

    // point table
    logic signed [OFF_W-1:0]    r_pd [MAX_POINTS];
    logic signed [WT_W-1:0]     r_pw [MAX_POINTS];

    t_state                     r_state;
    t_mode                      r_mode;
    logic [7:0]                 r_run;
    logic signed [WT_W-1:0]     r_ref;
    logic signed [WT_W-1:0]     r_cur;
    logic [CNT_W-1:0]           r_npts;
    logic                       r_rej;
    logic signed [OFF_W-1:0]    r_off;
    logic signed [WT_W-1:0]     r_kw;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_pos;
    logic signed [OFF_W-1:0]    r_lo_d;
    logic signed [WT_W-1:0]     r_lo_w;
    logic signed [OFF_W-1:0]    r_hi_d;
    logic signed [WT_W-1:0]     r_hi_w;
    logic signed [DIF_W-1:0]    r_a;
    logic signed [WB_W-1:0]     r_b;
    logic signed [DIF_W-1:0]    r_c;
    logic signed [WT_W-1:0]     r_base;
    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_out_data;

    logic [IDX_W-1:0]           w_rd_idx;
    logic signed [OFF_W-1:0]    w_rd_d;
    logic signed [WT_W-1:0]     w_rd_w;
    logic                       w_accept;
    logic signed [ADC_BITS-1:0] w_sample;
    logic signed [OFF_W-1:0]    w_off;
    logic                       w_out_free;
    t_md_req                    w_md_req;
    logic                       w_md_done;
    logic signed [QO_W-1:0]     w_md_quot;
    logic signed [QO_W:0]       w_sum;
    logic signed [WT_W-1:0]     w_sat;
    logic                       w_wr_en;
    logic signed [OFF_W-1:0]    w_wr_d;
    logic signed [WT_W-1:0]     w_wr_w;

    // classifier
    logic signed [WT_W:0]       w_cw;
    logic signed [WT_W:0]       w_thr;
    logic signed [WT_W+1:0]     w_dev_raw;
    logic signed [WT_W+1:0]     w_dev;
    logic [7:0]                 w_run_inc;
    t_mode                      n_mode;
    logic signed [WT_W-1:0]     n_ref;
    logic [7:0]                 n_run;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_sample      = $signed(s_axis_tdata[ADC_BITS-1:0]);
    assign w_off         = OFF_W'(w_sample) - OFF_W'(r_tare);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_rd_idx = (r_state == S_INS) ? IDX_W'(r_pos - 1'b1) : r_idx;
    assign w_rd_d   = r_pd[w_rd_idx];
    assign w_rd_w   = r_pw[w_rd_idx];

    assign w_md_req.start = (r_state == S_MD_GO);
    assign w_md_req.a     = r_a;
    assign w_md_req.b     = r_b;
    assign w_md_req.c     = r_c;

    lcw_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    assign w_sum = (QO_W+1)'(r_base) + (QO_W+1)'(w_md_quot);
    always_comb begin
        if (w_sum > (QO_W+1)'(32'sh7FFFFFFF)) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_sum < -(QO_W+1)'(33'sh080000000)) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sum[WT_W-1:0];
        end
    end

    // table write: shift an entry up, or drop the new point in place
    assign w_wr_en = (r_state == S_INS);
    always_comb begin
        if (r_pos != '0 && w_rd_w > r_kw) begin
            w_wr_d = w_rd_d;
            w_wr_w = w_rd_w;
        end else begin
            w_wr_d = r_off;
            w_wr_w = r_kw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_pd[r_pos] <= w_wr_d;
            r_pw[r_pos] <= w_wr_w;
        end
    end

    // stability classifier on r_cur
    assign w_cw      = (WT_W+1)'(r_cur);
    assign w_thr     = $signed({2'b00, r_thr});
    assign w_dev_raw = (WT_W+2)'(r_cur) - (WT_W+2)'(r_ref);
    assign w_dev     = w_dev_raw[WT_W+1] ? -w_dev_raw : w_dev_raw;
    assign w_run_inc = (r_run == 8'hFF) ? r_run : r_run + 8'd1;

    always_comb begin
        n_mode = r_mode;
        n_ref  = r_ref;
        n_run  = r_run;
        unique case (r_mode)
            MODE_IDLE: begin
                if (w_cw > w_thr) begin
                    n_mode = MODE_NEW;
                    n_ref  = r_cur;
                    n_run  = '0;
                end
            end
            MODE_NEW, MODE_STABLE, MODE_CHG_STABLE, MODE_CHG_UNSTAB: begin
                if (w_cw < w_thr) begin
                    n_mode = MODE_REMOVED;
                    n_ref  = r_cur;
                end else if (w_dev < $signed({3'b000, r_band})) begin
                    n_run = w_run_inc;
                    if (w_run_inc >= r_needed) begin
                        if (r_mode == MODE_NEW) begin
                            n_mode = MODE_STABLE;
                            n_ref  = r_cur;
                        end else if (r_mode == MODE_CHG_UNSTAB) begin
                            n_mode = MODE_CHG_STABLE;
                            n_ref  = r_cur;
                        end
                    end
                end else begin
                    n_run = '0;
                    n_ref = r_cur;
                    if (r_mode == MODE_STABLE || r_mode == MODE_CHG_STABLE) begin
                        n_mode = MODE_CHG_UNSTAB;
                    end
                end
            end
            MODE_REMOVED: begin
                n_mode = (w_cw < w_thr) ? MODE_IDLE : MODE_NEW;
                n_ref  = r_cur;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare   <= '0;
            r_thr    <= 31'd1280;
            r_band   <= 31'd512;
            r_needed <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARE:      r_tare   <= $signed(i_cfg_data[ADC_BITS-1:0]);
                CFG_THRESHOLD: r_thr    <= i_cfg_data[30:0];
                CFG_BAND:      r_band   <= i_cfg_data[30:0];
                CFG_NEEDED:    r_needed <= i_cfg_data[7:0];
                default:       r_needed <= r_needed;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_UNCAL;
            r_run       <= '0;
            r_ref       <= '0;
            r_cur       <= '0;
            r_npts      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_off <= w_off;
                        r_kw  <= $signed(s_axis_tdata[ADC_BITS+WT_W-1:ADC_BITS]);
                        r_rej <= 1'b0;
                        r_idx <= '0;
                        r_pos <= IDX_W'(r_npts);
                        unique case (t_cmd'(s_axis_tuser))
                            CMD_WEIGH: begin
                                if (r_npts == '0) begin
                                    r_cur   <= '0;
                                    r_state <= S_CLASS;
                                end else begin
                                    r_state <= S_W0;
                                end
                            end
                            CMD_ADD: begin
                                if (r_npts >= CNT_W'(MAX_POINTS)) begin
                                    r_rej   <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_INS;
                                end
                            end
                            CMD_CLEAR: begin
                                r_npts  <= '0;
                                r_mode  <= MODE_UNCAL;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_INS: begin
                    if (r_pos != '0 && w_rd_w > r_kw) begin
                        r_pos <= r_pos - 1'b1;
                    end else begin
                        r_npts  <= r_npts + 1'b1;
                        r_mode  <= MODE_IDLE;
                        r_state <= S_OUT;
                    end
                end
                S_W0: begin
                    r_lo_d <= w_rd_d;
                    r_lo_w <= w_rd_w;
                    if (r_npts == CNT_W'(1) || r_off <= w_rd_d) begin
                        if (w_rd_d == '0) begin
                            r_cur   <= '0;
                            r_state <= S_CLASS;
                        end else begin
                            // line through the origin
                            r_a     <= DIF_W'(r_off);
                            r_b     <= WB_W'(w_rd_w);
                            r_c     <= DIF_W'(w_rd_d);
                            r_base  <= '0;
                            r_state <= S_MD_GO;
                        end
                    end else begin
                        r_idx   <= IDX_W'(r_npts - 1'b1);
                        r_state <= S_TOP1;
                    end
                end
                S_TOP1: begin
                    r_hi_d  <= w_rd_d;
                    r_hi_w  <= w_rd_w;
                    r_idx   <= IDX_W'(r_npts - 2'd2);
                    r_state <= S_TOP2;
                end
                S_TOP2: begin
                    if (r_off >= r_hi_d) begin
                        if (r_hi_d == w_rd_d) begin
                            r_cur   <= r_hi_w;
                            r_state <= S_CLASS;
                        end else begin
                            r_a     <= DIF_W'(r_off) - DIF_W'(w_rd_d);
                            r_b     <= WB_W'(r_hi_w) - WB_W'(w_rd_w);
                            r_c     <= DIF_W'(r_hi_d) - DIF_W'(w_rd_d);
                            r_base  <= w_rd_w;
                            r_state <= S_MD_GO;
                        end
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_SCAN0;
                    end
                end
                S_SCAN0: begin
                    r_lo_d  <= w_rd_d;
                    r_lo_w  <= w_rd_w;
                    r_idx   <= IDX_W'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_off >= r_lo_d && r_off <= w_rd_d) begin
                        if (r_lo_d == w_rd_d) begin
                            r_cur   <= r_lo_w;
                            r_state <= S_CLASS;
                        end else begin
                            r_a     <= DIF_W'(r_off) - DIF_W'(r_lo_d);
                            r_b     <= WB_W'(w_rd_w) - WB_W'(r_lo_w);
                            r_c     <= DIF_W'(w_rd_d) - DIF_W'(r_lo_d);
                            r_base  <= r_lo_w;
                            r_state <= S_MD_GO;
                        end
                    end else begin
                        r_lo_d <= w_rd_d;
                        r_lo_w <= w_rd_w;
                        if (CNT_W'(r_idx) + 1'b1 == r_npts) begin
                            // no segment holds the sample
                            r_cur   <= '0;
                            r_state <= S_CLASS;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_MD_GO: r_state <= S_MD_WAIT;
                S_MD_WAIT: begin
                    if (w_md_done) begin
                        r_cur   <= w_sat;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    r_mode  <= n_mode;
                    r_ref   <= n_ref;
                    r_run   <= n_run;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register: load on the way out of S_OUT, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= {r_rej, 4'(r_npts), r_mode, r_cur};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_npts_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npts <= CNT_W'(MAX_POINTS))
        else $error("point count above table size");

    a_uncal_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_UNCAL) == (r_npts == '0))
        else $error("uncalibrated mode and point count disagree");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("ready right after a transfer");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == S_MD_WAIT))
        else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire
